/* design/rfd_pkg.sv */
// Shared constants, types and a helper function of the IPv4 forwarding decision block.
package rfd_pkg;

	localparam int RFD_ROUTE_ENTRIES = 16;
	localparam int RFD_NUM_PORTS     = 4;
	localparam int RFD_CFG_PORTS     = 4;
	localparam int RFD_IDX_W         = 4;
	localparam int RFD_CFG_IDX_W     = 3;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	localparam logic [15:0] ETH_IPV4      = 16'h0800;
	localparam logic [15:0] ETH_ARP       = 16'h0806;
	localparam logic [7:0]  PROTO_ICMP    = 8'd1;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
	localparam logic [15:0] ARP_REQUEST   = 16'd1;
	localparam logic [7:0]  TTL_EXPIRE    = 8'd1;

	localparam logic [RFD_CFG_IDX_W-1:0] CFG_PORT_ADDR_0  = 3'd0;
	localparam logic [RFD_CFG_IDX_W-1:0] CFG_PORT_ADDR_1  = 3'd1;
	localparam logic [RFD_CFG_IDX_W-1:0] CFG_PORT_ADDR_2  = 3'd2;
	localparam logic [RFD_CFG_IDX_W-1:0] CFG_PORT_ADDR_3  = 3'd3;
	localparam logic [RFD_CFG_IDX_W-1:0] CFG_PORTS_IN_USE = 3'd4;

	typedef enum logic [2:0] {
		ACT_NONE          = 3'd0,
		ACT_ARP_REPLY     = 3'd1,
		ACT_PORT_UNREACH  = 3'd2,
		ACT_TIME_EXCEEDED = 3'd3,
		ACT_ECHO_REPLY    = 3'd4,
		ACT_HOST_UNREACH  = 3'd5,
		ACT_NET_UNREACH   = 3'd6,
		ACT_FORWARD       = 3'd7
	} action_t;

	// One candidate route as it moves up the match tree.
	typedef struct packed {
		logic        hit;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [1:0]  port;
	} node_t;

	// Header verdict that travels alongside the match tree.
	typedef struct packed {
		action_t     act;
		logic        lpm;
		logic        ttl_one;
		logic [31:0] dst;
		logic [1:0]  in_port;
	} hdr_t;

	// Longer mask wins; on equal masks the higher slot (hi side) wins.
	function automatic node_t rfd_pick(node_t lo, node_t hi);
		return (hi.hit && (!lo.hit || hi.mask >= lo.mask)) ? hi : lo;
	endfunction

endpackage

/* design/rfd_if.sv */
// Valid/ready channel interfaces for input words and result words.
interface rfd_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [3:0]  entry_index;
	logic [31:0] address;
	logic [31:0] mask;
	logic [31:0] gateway;
	logic [1:0]  port;
	logic [15:0] ether_type;
	logic [7:0]  ip_proto;
	logic [7:0]  ttl;
	logic [7:0]  icmp_type;
	logic [15:0] arp_op;
	logic [31:0] arp_target;

	modport source (
		output valid, func, entry_index, address, mask, gateway, port, ether_type,
			ip_proto, ttl, icmp_type, arp_op, arp_target,
		input  ready
	);
	modport sink (
		input  valid, func, entry_index, address, mask, gateway, port, ether_type,
			ip_proto, ttl, icmp_type, arp_op, arp_target,
		output ready
	);
endinterface

interface rfd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [1:0]  out_port;
	logic [31:0] next_hop;
	logic        route_hit;

	modport source (
		output valid, action, out_port, next_hop, route_hit,
		input  ready
	);
	modport sink (
		input  valid, action, out_port, next_hop, route_hit,
		output ready
	);
endinterface

/* design/rfd_route_table.sv */
// Route table storage with one prefix compare cell per entry.
module rfd_route_table import rfd_pkg::*; #(
	parameter int ENTRIES = RFD_ROUTE_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [RFD_IDX_W-1:0] wr_index,
	input  logic [31:0]          wr_prefix,
	input  logic [31:0]          wr_mask,
	input  logic [31:0]          wr_gateway,
	input  logic [1:0]           wr_port,
	input  logic [31:0]          lookup_addr,
	output node_t [ENTRIES-1:0]  leaf
);

	logic [31:0]        prefix_q  [ENTRIES];
	logic [31:0]        mask_q    [ENTRIES];
	logic [31:0]        gateway_q [ENTRIES];
	logic [1:0]         port_q    [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] slot_we;

	for (genvar j = 0; j < ENTRIES; j++) begin : g_slot
		// Slots beyond the index range can never be addressed.
		if (j < (1 << RFD_IDX_W)) begin : g_wr
			assign slot_we[j] = wr_en && (wr_index == RFD_IDX_W'(j));
		end else begin : g_nowr
			assign slot_we[j] = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[j] <= 1'b0;
			end else if (slot_we[j]) begin
				valid_q[j] <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (slot_we[j]) begin
				prefix_q[j]  <= wr_prefix;
				mask_q[j]    <= wr_mask;
				gateway_q[j] <= wr_gateway;
				port_q[j]    <= wr_port;
			end
		end

		assign leaf[j].hit     = valid_q[j] && ((lookup_addr & mask_q[j]) == prefix_q[j]);
		assign leaf[j].mask    = mask_q[j];
		assign leaf[j].gateway = gateway_q[j];
		assign leaf[j].port    = port_q[j];
	end

endmodule

/* design/rfd_lpm_tree.sv */
// Pipelined longest-prefix selection tree, one level per register stage.
module rfd_lpm_tree import rfd_pkg::*; #(
	parameter int ENTRIES = RFD_ROUTE_ENTRIES
) (
	input  logic                clk,
	input  logic                adv,
	input  node_t [ENTRIES-1:0] leaf,
	output node_t               root
);

	localparam int LEVELS = $clog2(ENTRIES);
	localparam int LEAVES = 1 << LEVELS;
	localparam int NODES  = 2 * LEAVES - 1;

	// Heap order: children of node i are 2i+1 (lower slots) and 2i+2 (higher slots).
	node_t heap_s [NODES];

	for (genvar i = 0; i < NODES; i++) begin : g_node
		if (i >= LEAVES - 1) begin : g_leaf
			if (i - (LEAVES - 1) < ENTRIES) begin : g_used
				always_ff @(posedge clk) begin
					if (adv) begin
						heap_s[i] <= leaf[i-(LEAVES-1)];
					end
				end
			end else begin : g_pad
				always_ff @(posedge clk) begin
					if (adv) begin
						heap_s[i] <= '0;
					end
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (adv) begin
					heap_s[i] <= rfd_pick(heap_s[2*i+1], heap_s[2*i+2]);
				end
			end
		end
	end

	assign root = heap_s[0];

endmodule

/* design/rfd_hdr_check.sv */
// Header classification and its delay line aligned with the match tree.
module rfd_hdr_check import rfd_pkg::*; #(
	parameter int DEPTH = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            take,
	input  logic [31:0]                     address,
	input  logic [1:0]                      port,
	input  logic [15:0]                     ether_type,
	input  logic [7:0]                      ip_proto,
	input  logic [7:0]                      ttl,
	input  logic [7:0]                      icmp_type,
	input  logic [15:0]                     arp_op,
	input  logic [31:0]                     arp_target,
	input  logic [RFD_CFG_PORTS-1:0][31:0]  port_addr,
	input  logic [2:0]                      ports_in_use,
	output hdr_t                            hdr,
	output logic                            hdr_valid
);

	hdr_t             hdr_d;
	hdr_t             hdr_s [DEPTH];
	logic [DEPTH-1:0] vld_s;
	logic [31:0]      ing_addr;
	logic             other_hit;

	assign ing_addr = port_addr[port];

	always_comb begin
		other_hit = 1'b0;
		for (int i = 0; i < RFD_NUM_PORTS; i++) begin
			if ((3'(i) < ports_in_use) && (port_addr[i] == address)) begin
				other_hit = 1'b1;
			end
		end
	end

	always_comb begin
		hdr_d.act     = ACT_NONE;
		hdr_d.lpm     = 1'b0;
		hdr_d.ttl_one = (ttl == TTL_EXPIRE);
		hdr_d.dst     = address;
		hdr_d.in_port = port;
		if (ether_type == ETH_ARP) begin
			if (arp_op == ARP_REQUEST && arp_target == ing_addr) begin
				hdr_d.act = ACT_ARP_REPLY;
			end
		end else if (ether_type == ETH_IPV4) begin
			if (address == ing_addr) begin
				if (ip_proto == PROTO_TCP || ip_proto == PROTO_UDP) begin
					hdr_d.act = ACT_PORT_UNREACH;
				end else if (ttl == TTL_EXPIRE) begin
					hdr_d.act = ACT_TIME_EXCEEDED;
				end else if (ip_proto == PROTO_ICMP && icmp_type == ICMP_ECHO_REQ) begin
					hdr_d.act = ACT_ECHO_REPLY;
				end
			end else if (other_hit) begin
				hdr_d.act = ACT_HOST_UNREACH;
			end else begin
				hdr_d.lpm = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= DEPTH'({vld_s, take});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hdr_s[0] <= hdr_d;
			for (int k = 1; k < DEPTH; k++) begin
				hdr_s[k] <= hdr_s[k-1];
			end
		end
	end

	assign hdr       = hdr_s[DEPTH-1];
	assign hdr_valid = vld_s[DEPTH-1];

endmodule

/* design/ipv4_forwarding_decision.sv */
// Top level of the IPv4 forwarding decision pipeline.
//
// Router forwarding decision. A word on the item channel with func = 0 stores
// one route (prefix, mask, gateway, egress port) in slot entry_index of a
// table of ROUTE_ENTRIES entries; it gives no result and takes effect for every
// frame accepted after it. A word with func = 1 carries parsed header fields
// and yields exactly one result word: ARP reply, ICMP port unreachable, time
// exceeded or echo reply for traffic to the ingress port's address, host
// unreachable for another local port's address, and otherwise a longest-prefix
// match (longest mask wins, later slot on a tie) giving forward, time exceeded
// when TTL is 1, or net unreachable on a miss. The pipeline takes one word per
// clock unless a result word stalls. A frame's result is built in order: the
// accept edge registers the compare of the destination against every table
// entry, clog2(ROUTE_ENTRIES) stages each halve the candidate set in the
// selection tree, and a final stage forms the result in the output register.
// When the result word is not taken the whole pipeline holds, and item.ready
// drops with it. Port addresses and ports_in_use are written through
// cfg_we/cfg_index/cfg_data; write them only while no frame is in flight.
// Table entries come out of reset invalid.
module ipv4_forwarding_decision import rfd_pkg::*; #(
	parameter int ROUTE_ENTRIES = RFD_ROUTE_ENTRIES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	rfd_in_if.sink                   item,
	rfd_out_if.source                result,
	input  logic                     cfg_we,
	input  logic [RFD_CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]              cfg_data
);

	localparam int LEVELS = $clog2(ROUTE_ENTRIES);

	logic [RFD_CFG_PORTS-1:0][31:0] port_addr_q;
	logic [2:0]                     ports_in_use_q;

	logic                     pipe_adv;
	logic                     wr_en;
	logic                     take;
	node_t [ROUTE_ENTRIES-1:0] leaf;
	node_t                    root;
	hdr_t                     hdr;
	logic                     hdr_valid;

	action_t     act_d;
	logic [1:0]  port_d;
	logic [31:0] hop_d;
	logic        hit_d;

	logic        out_valid_q;
	action_t     out_act_q;
	logic [1:0]  out_port_q;
	logic [31:0] out_hop_q;
	logic        out_hit_q;

	// Advance the whole pipe whenever the output register is free or being drained.
	assign pipe_adv   = !out_valid_q || result.ready;
	assign item.ready = pipe_adv;
	assign wr_en      = item.valid && pipe_adv && (item.func == FUNC_WRITE);
	assign take       = item.valid && (item.func == FUNC_FRAME);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_addr_q    <= '0;
			ports_in_use_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PORT_ADDR_0:  port_addr_q[0] <= cfg_data;
				CFG_PORT_ADDR_1:  port_addr_q[1] <= cfg_data;
				CFG_PORT_ADDR_2:  port_addr_q[2] <= cfg_data;
				CFG_PORT_ADDR_3:  port_addr_q[3] <= cfg_data;
				CFG_PORTS_IN_USE: ports_in_use_q <= cfg_data[2:0];
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	// Table writes land at the accept edge, so a frame right behind a write sees it.
	rfd_route_table #(
		.ENTRIES (ROUTE_ENTRIES)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (item.entry_index),
		.wr_prefix   (item.address),
		.wr_mask     (item.mask),
		.wr_gateway  (item.gateway),
		.wr_port     (item.port),
		.lookup_addr (item.address),
		.leaf        (leaf)
	);

	rfd_lpm_tree #(
		.ENTRIES (ROUTE_ENTRIES)
	) u_tree (
		.clk  (clk),
		.adv  (pipe_adv),
		.leaf (leaf),
		.root (root)
	);

	// Header verdict rides in step with the tree: one stage for the leaves, one per level.
	rfd_hdr_check #(
		.DEPTH (LEVELS + 1)
	) u_hdr (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (pipe_adv),
		.take         (take),
		.address      (item.address),
		.port         (item.port),
		.ether_type   (item.ether_type),
		.ip_proto     (item.ip_proto),
		.ttl          (item.ttl),
		.icmp_type    (item.icmp_type),
		.arp_op       (item.arp_op),
		.arp_target   (item.arp_target),
		.port_addr    (port_addr_q),
		.ports_in_use (ports_in_use_q),
		.hdr          (hdr),
		.hdr_valid    (hdr_valid)
	);

	// Merge the header verdict with the route lookup.
	always_comb begin
		act_d  = hdr.act;
		port_d = hdr.in_port;
		hop_d  = '0;
		hit_d  = 1'b0;
		if (hdr.lpm) begin
			if (root.hit) begin
				hit_d = 1'b1;
				if (hdr.ttl_one) begin
					act_d = ACT_TIME_EXCEEDED;
				end else begin
					act_d  = ACT_FORWARD;
					port_d = root.port;
					// Directly attached route: next hop is the destination itself.
					hop_d  = (root.gateway != '0) ? root.gateway : hdr.dst;
				end
			end else begin
				act_d = ACT_NET_UNREACH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_adv) begin
			out_valid_q <= hdr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_adv) begin
			out_act_q  <= act_d;
			out_port_q <= port_d;
			out_hop_q  <= hop_d;
			out_hit_q  <= hit_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.action    = out_act_q;
	assign result.out_port  = out_port_q;
	assign result.next_hop  = out_hop_q;
	assign result.route_hit = out_hit_q;

`ifndef SYNTHESIS
	// A result word waiting on the sink must hold off new input words.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !item.ready)
		else $error("input accepted while result word stalled");

	// A new result word may only appear on a cycle where the pipe advanced.
	a_valid_rise_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(pipe_adv))
		else $error("result word appeared without pipeline advance");

	// A route hit only ever yields forward or time exceeded.
	a_hit_action: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.route_hit) |->
			(result.action == ACT_FORWARD || result.action == ACT_TIME_EXCEEDED))
		else $error("route hit with unexpected action");
`endif

endmodule

/* tb/rfd_check_pkg.sv */
`timescale 1ns / 1ps
// Word types and the decision scoreboard for the forwarding decision testbench.
package rfd_check_pkg;
	import rfd_pkg::*;

	typedef struct packed {
		logic        func;
		logic [3:0]  entry_index;
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [1:0]  port;
		logic [15:0] ether_type;
		logic [7:0]  ip_proto;
		logic [7:0]  ttl;
		logic [7:0]  icmp_type;
		logic [15:0] arp_op;
		logic [31:0] arp_target;
	} in_word_t;

	typedef struct packed {
		action_t     action;
		logic [1:0]  out_port;
		logic [31:0] next_hop;
		logic        route_hit;
	} decision_t;

	class decision_board;
		logic [31:0] port_addr [RFD_CFG_PORTS];
		logic [2:0]  ports_in_use;
		logic [31:0] prefix_of [RFD_ROUTE_ENTRIES];
		logic [31:0] mask_of [RFD_ROUTE_ENTRIES];
		logic [31:0] gateway_of [RFD_ROUTE_ENTRIES];
		logic [1:0]  egress_of [RFD_ROUTE_ENTRIES];
		bit          live [RFD_ROUTE_ENTRIES];
		decision_t   awaited [$];
		int          failures;

		function new();
			for (int i = 0; i < RFD_CFG_PORTS; i++) port_addr[i] = '0;
			ports_in_use = 3'd4;
			for (int i = 0; i < RFD_ROUTE_ENTRIES; i++) live[i] = 1'b0;
			failures = 0;
		endfunction

		function void write_register(logic [RFD_CFG_IDX_W-1:0] index, logic [31:0] data);
			case (index)
				CFG_PORT_ADDR_0:  port_addr[0] = data;
				CFG_PORT_ADDR_1:  port_addr[1] = data;
				CFG_PORT_ADDR_2:  port_addr[2] = data;
				CFG_PORT_ADDR_3:  port_addr[3] = data;
				CFG_PORTS_IN_USE: ports_in_use = data[2:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function decision_t decide(in_word_t w);
			decision_t   d;
			logic [31:0] best_mask;
			int          slot;
			int          compared;
			bit          hit;
			bit          other;
			d.action    = ACT_NONE;
			d.out_port  = w.port;
			d.next_hop  = '0;
			d.route_hit = 1'b0;
			if (w.ether_type == ETH_ARP) begin
				if (w.arp_op == ARP_REQUEST && w.arp_target == port_addr[w.port])
					d.action = ACT_ARP_REPLY;
			end else if (w.ether_type == ETH_IPV4) begin
				// ports above the built count are never compared
				compared = (int'(ports_in_use) > RFD_NUM_PORTS) ? RFD_NUM_PORTS
					: int'(ports_in_use);
				other = 1'b0;
				for (int i = 0; i < compared; i++)
					if (port_addr[i] == w.address) other = 1'b1;
				hit = 1'b0;
				best_mask = '0;
				slot = 0;
				// >= lets the higher slot take a tie
				for (int i = 0; i < RFD_ROUTE_ENTRIES; i++)
					if (live[i] && (w.address & mask_of[i]) == prefix_of[i]
							&& mask_of[i] >= best_mask) begin
						best_mask = mask_of[i];
						slot = i;
						hit = 1'b1;
					end
				if (w.address == port_addr[w.port]) begin
					if (w.ip_proto == PROTO_TCP || w.ip_proto == PROTO_UDP)
						d.action = ACT_PORT_UNREACH;
					else if (w.ttl == TTL_EXPIRE)
						d.action = ACT_TIME_EXCEEDED;
					else if (w.ip_proto == PROTO_ICMP && w.icmp_type == ICMP_ECHO_REQ)
						d.action = ACT_ECHO_REPLY;
				end else if (other) begin
					d.action = ACT_HOST_UNREACH;
				end else if (hit) begin
					d.route_hit = 1'b1;
					if (w.ttl == TTL_EXPIRE) begin
						d.action = ACT_TIME_EXCEEDED;
					end else begin
						d.action   = ACT_FORWARD;
						d.out_port = egress_of[slot];
						d.next_hop = (gateway_of[slot] != '0) ? gateway_of[slot] : w.address;
					end
				end else begin
					d.action = ACT_NET_UNREACH;
				end
			end
			return d;
		endfunction

		function void note_word(in_word_t w);
			if (w.func == FUNC_WRITE) begin
				if (int'(w.entry_index) < RFD_ROUTE_ENTRIES) begin
					prefix_of[w.entry_index]  = w.address;
					mask_of[w.entry_index]    = w.mask;
					gateway_of[w.entry_index] = w.gateway;
					egress_of[w.entry_index]  = w.port;
					live[w.entry_index]       = 1'b1;
				end
			end else begin
				awaited.push_back(decide(w));
			end
		endfunction

		function void check_decision(decision_t got);
			decision_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected decision action %0d port %0d hop %h hit %0b",
						$time, got.action, got.out_port, got.next_hop, got.route_hit);
				return;
			end
			want = awaited.pop_front();
			if (got.action !== want.action || got.out_port !== want.out_port
					|| got.next_hop !== want.next_hop || got.route_hit !== want.route_hit) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: decision differs: expected action %0d port %0d hop %h hit %0b",
						$time, want.action, want.out_port, want.next_hop, want.route_hit);
					$display("%0t:   got action %0d port %0d hop %h hit %0b",
						$time, got.action, got.out_port, got.next_hop, got.route_hit);
				end
			end
		endfunction
	endclass

endpackage

/* tb/ipv4_forwarding_decision_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the IPv4 forwarding decision block.
module ipv4_forwarding_decision_test;
	import rfd_pkg::*;
	import rfd_check_pkg::*;

	localparam int PERIOD          = 10;
	localparam int LATENCY         = $clog2(RFD_ROUTE_ENTRIES) + 2;
	localparam int HOLD_OFF        = 2 * LATENCY + 4;
	localparam int CYCLE_LIMIT     = 400_000;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int RANDOM_PHASES   = 6;

	localparam logic [15:0] ARP_REPLY_OP = 16'd2;

	// Port addresses for the directed part; port 3 sits at the all-ones extreme.
	localparam logic [31:0] ADDR_P0 = 32'h0A00_0001;
	localparam logic [31:0] ADDR_P1 = 32'hC0A8_0101;
	localparam logic [31:0] ADDR_P2 = 32'hAC10_0001;
	localparam logic [31:0] ADDR_P3 = 32'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [RFD_CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// Drop all idling once the last phase starts.
	bit steady = 1'b0;
	int cycle_count = 0;

	decision_board board;
	decision_t observed;
	logic [2:0] in_use_plan [RANDOM_PHASES] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5};
	logic [31:0] plan_addr [RFD_CFG_PORTS];

	rfd_in_if item ();
	rfd_out_if result ();

	ipv4_forwarding_decision DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Bound the run in case the block stops moving words.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ipv4_forwarding_decision: mismatch");
			$finish;
		end
	end

	// Check every decision word at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1) begin
			observed.action    = action_t'(result.action);
			observed.out_port  = result.out_port;
			observed.next_hop  = result.next_hop;
			observed.route_hit = result.route_hit;
			board.check_decision(observed);
		end
	end

	// Stall the result channel in random bursts; hold ready high once steady.
	initial begin
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!steady && $urandom_range(0, 2) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			result.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// Fill every field with noise; builders then set the fields that matter.
	function automatic in_word_t noise_word();
		in_word_t w;
		w.func        = 1'($urandom);
		w.entry_index = 4'($urandom);
		w.address     = $urandom;
		w.mask        = $urandom;
		w.gateway     = $urandom;
		w.port        = 2'($urandom);
		w.ether_type  = 16'($urandom);
		w.ip_proto    = 8'($urandom);
		w.ttl         = 8'($urandom);
		w.icmp_type   = 8'($urandom);
		w.arp_op      = 16'($urandom);
		w.arp_target  = $urandom;
		return w;
	endfunction

	function automatic in_word_t route_word(logic [3:0] slot, logic [31:0] prefix,
			logic [31:0] mask, logic [31:0] gateway, logic [1:0] egress);
		in_word_t w;
		w = noise_word();
		w.func        = FUNC_WRITE;
		w.entry_index = slot;
		w.address     = prefix;
		w.mask        = mask;
		w.gateway     = gateway;
		w.port        = egress;
		return w;
	endfunction

	function automatic in_word_t frame_word(logic [15:0] etype, logic [1:0] ingress,
			logic [31:0] dst);
		in_word_t w;
		w = noise_word();
		w.func       = FUNC_FRAME;
		w.ether_type = etype;
		w.port       = ingress;
		w.address    = dst;
		return w;
	endfunction

	function automatic in_word_t ipv4_word(logic [1:0] ingress, logic [31:0] dst,
			logic [7:0] proto, logic [7:0] ttl, logic [7:0] itype);
		in_word_t w;
		w = frame_word(ETH_IPV4, ingress, dst);
		w.ip_proto  = proto;
		w.ttl       = ttl;
		w.icmp_type = itype;
		return w;
	endfunction

	function automatic in_word_t arp_word(logic [1:0] ingress, logic [15:0] op,
			logic [31:0] target);
		in_word_t w;
		w = frame_word(ETH_ARP, ingress, $urandom);
		w.arp_op     = op;
		w.arp_target = target;
		return w;
	endfunction

	// Mostly well-formed traffic: prefix-aligned routes, destinations that land
	// on port addresses or inside stored prefixes, and ARP aimed at the ports.
	function automatic in_word_t random_word();
		in_word_t w;
		int live_slots [RFD_ROUTE_ENTRIES];
		int n_live;
		int len;
		int s;
		logic [1:0] j;
		w = noise_word();
		n_live = 0;
		for (int i = 0; i < RFD_ROUTE_ENTRIES; i++)
			if (board.live[i]) begin
				live_slots[n_live] = i;
				n_live++;
			end
		j = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) begin
			w.func = FUNC_WRITE;
			if ($urandom_range(0, 9) != 0) begin
				len = $urandom_range(0, 32);
				w.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
			end
			// an unaligned prefix can never match; keep those rare
			if ($urandom_range(0, 9) != 0) w.address = w.address & w.mask;
			case ($urandom_range(0, 3))
				0: w.gateway = '0;
				1: w.gateway = board.port_addr[j];
				default: ;
			endcase
			return w;
		end
		w.func = FUNC_FRAME;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				w.address = board.port_addr[j];
				if ($urandom_range(0, 1) == 0) w.port = j;
			end
			3, 4, 5, 6: begin
				if (n_live != 0) begin
					s = live_slots[$urandom_range(0, n_live - 1)];
					w.address = board.prefix_of[s] | (w.address & ~board.mask_of[s]);
				end
			end
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: w.ether_type = ETH_IPV4;
			5, 6, 7: w.ether_type = ETH_ARP;
			8: ;
			default: w.ether_type = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
		endcase
		case ($urandom_range(0, 3))
			0: w.ip_proto = PROTO_ICMP;
			1: w.ip_proto = PROTO_TCP;
			2: w.ip_proto = PROTO_UDP;
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0: w.ttl = 8'd0;
			1: w.ttl = TTL_EXPIRE;
			2: w.ttl = 8'hFF;
			default: ;
		endcase
		if ($urandom_range(0, 1) == 0) w.icmp_type = ICMP_ECHO_REQ;
		case ($urandom_range(0, 4))
			0, 1, 2: w.arp_op = ARP_REQUEST;
			3: w.arp_op = ARP_REPLY_OP;
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0, 1, 2: w.arp_target = board.port_addr[w.port];
			3: w.arp_target = board.port_addr[j];
			default: ;
		endcase
		return w;
	endfunction

	// Offer one word, with an optional idle burst first; return at the edge that takes it.
	task automatic send(in_word_t w);
		if (!steady && $urandom_range(0, 3) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item.valid       <= 1'b1;
		item.func        <= w.func;
		item.entry_index <= w.entry_index;
		item.address     <= w.address;
		item.mask        <= w.mask;
		item.gateway     <= w.gateway;
		item.port        <= w.port;
		item.ether_type  <= w.ether_type;
		item.ip_proto    <= w.ip_proto;
		item.ttl         <= w.ttl;
		item.icmp_type   <= w.icmp_type;
		item.arp_op      <= w.arp_op;
		item.arp_target  <= w.arp_target;
		@(posedge clk);
		while (item.ready !== 1'b1) @(posedge clk);
		board.note_word(w);
	endtask

	// Drain the pipeline: no decision outstanding, and time for a trailing route write.
	task automatic settle();
		item.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic drive_reg(logic [RFD_CFG_IDX_W-1:0] index, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		board.write_register(index, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_ports(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
			logic [31:0] a3, logic [2:0] in_use);
		settle();
		drive_reg(CFG_PORT_ADDR_0, a0);
		drive_reg(CFG_PORT_ADDR_1, a1);
		drive_reg(CFG_PORT_ADDR_2, a2);
		drive_reg(CFG_PORT_ADDR_3, a3);
		drive_reg(CFG_PORTS_IN_USE, 32'(in_use));
	endtask

	initial begin
		board = new();
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		item.valid       <= 1'b0;
		item.func        <= FUNC_WRITE;
		item.entry_index <= '0;
		item.address     <= '0;
		item.mask        <= '0;
		item.gateway     <= '0;
		item.port        <= '0;
		item.ether_type  <= '0;
		item.ip_proto    <= '0;
		item.ttl         <= '0;
		item.icmp_type   <= '0;
		item.arp_op      <= '0;
		item.arp_target  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: every port at address 0, all four compared, table empty.
		send(ipv4_word(2'd2, 32'h0, PROTO_ICMP, 8'd64, ICMP_ECHO_REQ));
		send(ipv4_word(2'd1, 32'h0102_0304, PROTO_TCP, 8'd64, 8'd0));

		program_ports(ADDR_P0, ADDR_P1, ADDR_P2, ADDR_P3, 3'd4);
		// Default route, a /16 written twice so the later slot takes the tie,
		// a /8 with no gateway, and an all-ones host route.
		send(route_word(4'd0, 32'h0, 32'h0, 32'h0A00_00FE, 2'd1));
		send(route_word(4'd5, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 2'd2));
		send(route_word(4'd9, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_01FE, 2'd3));
		send(route_word(4'd15, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
		send(route_word(4'd3, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 2'd0));

		// TTL 0 still forwards; gateway zero hands back the destination; TTL 1 on a hit.
		send(ipv4_word(2'd1, 32'h0A01_0203, PROTO_UDP, 8'd0, 8'd0));
		send(ipv4_word(2'd1, 32'h0A02_0304, PROTO_ICMP, 8'hFF, ICMP_ECHO_REQ));
		send(ipv4_word(2'd2, 32'h0A02_0304, PROTO_TCP, TTL_EXPIRE, 8'd0));
		send(ipv4_word(2'd3, 32'h0808_0808, 8'hFF, 8'd64, 8'hFF));
		send(ipv4_word(2'd2, 32'hFFFF_FFFE, PROTO_ICMP, 8'd64, 8'd0));

		// ARP answered only for a request aimed at the ingress port.
		send(arp_word(2'd1, ARP_REQUEST, ADDR_P1));
		send(arp_word(2'd1, ARP_REQUEST, ADDR_P0));
		send(arp_word(2'd1, ARP_REPLY_OP, ADDR_P1));
		send(frame_word(16'hFFFF, 2'd0, ADDR_P0));

		// Traffic to the ingress address, in order of precedence.
		send(ipv4_word(2'd2, ADDR_P2, PROTO_TCP, 8'd64, 8'd0));
		send(ipv4_word(2'd2, ADDR_P2, PROTO_UDP, TTL_EXPIRE, 8'd0));
		send(ipv4_word(2'd2, ADDR_P2, PROTO_ICMP, TTL_EXPIRE, ICMP_ECHO_REQ));
		send(ipv4_word(2'd3, ADDR_P3, PROTO_ICMP, 8'd64, ICMP_ECHO_REQ));
		send(ipv4_word(2'd3, ADDR_P3, PROTO_ICMP, 8'd64, 8'd0));
		send(ipv4_word(2'd0, ADDR_P0, 8'hFF, 8'd64, ICMP_ECHO_REQ));
		send(ipv4_word(2'd0, ADDR_P3, PROTO_ICMP, 8'd64, ICMP_ECHO_REQ));

		// With two ports compared, port 3's address falls through to the table,
		// yet it still counts as local when it is the ingress port.
		program_ports(ADDR_P0, ADDR_P1, ADDR_P2, ADDR_P3, 3'd2);
		send(ipv4_word(2'd0, ADDR_P3, PROTO_ICMP, 8'd64, ICMP_ECHO_REQ));
		send(ipv4_word(2'd3, ADDR_P3, PROTO_ICMP, 8'd64, ICMP_ECHO_REQ));

		// Random phases, each under its own port settings; the table carries over.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < RFD_CFG_PORTS; i++) plan_addr[i] = $urandom;
			if (p == 1) begin
				plan_addr[0] = 32'h0;
				plan_addr[1] = 32'hFFFF_FFFF;
				plan_addr[2] = 32'h0;
				plan_addr[3] = 32'hFFFF_FFFF;
			end
			if (p == RANDOM_PHASES - 1) steady = 1'b1;
			program_ports(plan_addr[0], plan_addr[1], plan_addr[2], plan_addr[3],
				in_use_plan[p]);
			repeat (ITEMS_PER_PHASE) send(random_word());
		end

		settle();
		if (board.failures == 0 && board.pending() == 0) begin
			$display("ipv4_forwarding_decision: match");
		end else begin
			$display("ipv4_forwarding_decision: mismatch");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/rfd_pkg.sv
design/rfd_if.sv
design/rfd_route_table.sv
design/rfd_lpm_tree.sv
design/rfd_hdr_check.sv
design/ipv4_forwarding_decision.sv
tb/rfd_check_pkg.sv
tb/ipv4_forwarding_decision_test.sv
